### src/rqh_pkg.sv
`default_nettype none
package rqh_pkg;

   // fixed formats
   localparam int FRAC_BITS_DEF = 16;
   localparam int FIX_W         = 32;
   localparam int WORD_W        = 64;
   localparam int TAG_W         = 16;
   localparam int NUM_STAGES    = 12;

   // register file
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_DIR_Z    = 3'd5;

   localparam logic signed [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // 64-bit add that clips at the signed limits
   function automatic logic signed [WORD_W-1:0] sat_add64(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b
   );
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? S64_MIN : S64_MAX;
      end
      return $signed(s[WORD_W-1:0]);
   endfunction

endpackage
`default_nettype wire

### src/rqh_if.sv
`default_nettype none
// transform words in
interface rqh_req_if;
   logic                      valid;
   logic                      ready;
   logic [rqh_pkg::WORD_W-1:0] row0_cols01;
   logic [rqh_pkg::WORD_W-1:0] row0_cols23;
   logic [rqh_pkg::WORD_W-1:0] row1_cols01;
   logic [rqh_pkg::WORD_W-1:0] row1_cols23;
   logic [rqh_pkg::WORD_W-1:0] row2_cols01;
   logic [rqh_pkg::WORD_W-1:0] row2_cols23;
   logic [rqh_pkg::TAG_W-1:0]  entity_tag;

   modport source (output valid, row0_cols01, row0_cols23, row1_cols01, row1_cols23,
                   row2_cols01, row2_cols23, entity_tag, input ready);
   modport sink (input valid, row0_cols01, row0_cols23, row1_cols01, row1_cols23,
                 row2_cols01, row2_cols23, entity_tag, output ready);
endinterface

// hit words out
interface rqh_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [rqh_pkg::TAG_W-1:0] result_tag;
   logic                     hit;

   modport source (output valid, result_tag, hit, input ready);
   modport sink (input valid, result_tag, hit, output ready);
endinterface
`default_nettype wire

### src/ray_quad_hit_test.sv
`default_nettype none
// Ray against unit quad, one entity transform per word.
// csr_*: write the ray (origin x/y/z, direction x/y/z, signed fixed point)
//   with csr_we high for one cycle per register; write only while idle.
// req_chan: one 3x4 affine transform and a tag per word.
// rsp_chan: one word per request, same order: the tag and the hit flag.
//   An any-hit answer is the OR of the hit flags.
// Throughput: one word per cycle while rsp_chan does not stall. Depth: 12
//   register stages, the last of which drives rsp_chan. The depth is set by
//   the 64x64 exact products, each cut into 32x32 partial products over two
//   stages.
// Stall: each stage holds its word while the next one is full and stalled;
//   empty stages keep filling, so req_chan.ready only drops once the whole
//   pipe is full behind a stalled rsp_chan.
// Reset: synchronous; empties the pipe and clears the ray to zero.
module ray_quad_hit_test #(
   parameter int FRAC_BITS = rqh_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rqh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rqh_pkg::FIX_W-1:0]     csr_wdata,
   rqh_req_if.sink                       req_chan,
   rqh_rsp_if.source                     rsp_chan
);
   import rqh_pkg::*;

   localparam int ADJ_W = WORD_W - FRAC_BITS;

   logic signed [FIX_W-1:0]  origin_ff [3];
   logic signed [FIX_W-1:0]  dir_ff [3];
   logic [NUM_STAGES-1:0]    vld_ff;
   logic [NUM_STAGES:0]      adv;
   logic [TAG_W-1:0]         tag_ff [NUM_STAGES];
   logic [WORD_W-1:0]        row_words [6];
   logic signed [ADJ_W-1:0]  adj [3][3];
   logic signed [FIX_W-1:0]  a0 [3];
   logic signed [FIX_W:0]    rel [3];
   logic signed [WORD_W-1:0] det;
   logic signed [WORD_W-1:0] loc_org [3];
   logic signed [WORD_W-1:0] loc_dir [3];
   logic                     hit;

   // ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            origin_ff[j] <= '0;
            dir_ff[j]    <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAY_ORIGIN_X: origin_ff[0] <= $signed(csr_wdata);
            CSR_RAY_ORIGIN_Y: origin_ff[1] <= $signed(csr_wdata);
            CSR_RAY_ORIGIN_Z: origin_ff[2] <= $signed(csr_wdata);
            CSR_RAY_DIR_X:    dir_ff[0]    <= $signed(csr_wdata);
            CSR_RAY_DIR_Y:    dir_ff[1]    <= $signed(csr_wdata);
            CSR_RAY_DIR_Z:    dir_ff[2]    <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // stage k moves when empty or when stage k+1 moves
   always_comb begin
      adv[NUM_STAGES] = rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // tag rides alongside the datapath
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tag_ff[0] <= req_chan.entity_tag;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign row_words[0] = req_chan.row0_cols01;
   assign row_words[1] = req_chan.row0_cols23;
   assign row_words[2] = req_chan.row1_cols01;
   assign row_words[3] = req_chan.row1_cols23;
   assign row_words[4] = req_chan.row2_cols01;
   assign row_words[5] = req_chan.row2_cols23;

   rqh_adjugate #(.FRAC_BITS(FRAC_BITS)) u_adjugate (
      .clock      (clock),
      .stage_en   (adv[2:0]),
      .row_words  (row_words),
      .ray_origin (origin_ff),
      .adj        (adj),
      .a0         (a0),
      .rel        (rel)
   );

   rqh_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
      .clock    (clock),
      .stage_en (adv[6:3]),
      .adj      (adj),
      .a0       (a0),
      .rel      (rel),
      .ray_dir  (dir_ff),
      .det      (det),
      .loc_org  (loc_org),
      .loc_dir  (loc_dir)
   );

   rqh_bounds u_bounds (
      .clock    (clock),
      .stage_en (adv[11:7]),
      .det      (det),
      .loc_org  (loc_org),
      .loc_dir  (loc_dir),
      .hit      (hit)
   );

   assign req_chan.ready      = adv[0];
   assign rsp_chan.valid      = vld_ff[NUM_STAGES-1];
   assign rsp_chan.result_tag = tag_ff[NUM_STAGES-1];
   assign rsp_chan.hit        = hit;

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (vld_ff == '0))
      else $error("pipe not empty after reset");

   // an accepted word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted word lost at entry");

   // a stalled output stage keeps its word and tag
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      !adv[NUM_STAGES-1] |=> (vld_ff[NUM_STAGES-1] && $stable(tag_ff[NUM_STAGES-1])))
      else $error("stalled result dropped or changed");

   // a taken result with nothing behind it empties the output stage
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !vld_ff[NUM_STAGES-2]) |=> !vld_ff[NUM_STAGES-1])
      else $error("result repeated");

endmodule
`default_nettype wire

### src/rqh_adjugate.sv
`default_nettype none
// Stages 0..2: capture matrix, cofactor products, adjugate entries.
module rqh_adjugate #(
   parameter int FRAC_BITS = rqh_pkg::FRAC_BITS_DEF,
   localparam int ADJ_W = rqh_pkg::WORD_W - FRAC_BITS
) (
   input  logic                                   clock,
   input  logic [2:0]                             stage_en,
   input  logic [rqh_pkg::WORD_W-1:0]             row_words [6],
   input  logic signed [rqh_pkg::FIX_W-1:0]       ray_origin [3],
   output logic signed [ADJ_W-1:0]                adj [3][3],
   output logic signed [rqh_pkg::FIX_W-1:0]       a0 [3],
   output logic signed [rqh_pkg::FIX_W:0]         rel [3]
);
   import rqh_pkg::*;

   logic signed [FIX_W-1:0]  mat_ff [3][4];
   logic signed [FIX_W-1:0]  mat_in [3][4];
   logic signed [WORD_W-1:0] prod_ff [9][2];
   logic signed [WORD_W-1:0] prod_in [9][2];
   logic signed [FIX_W-1:0]  a0_s1_ff [3];
   logic signed [FIX_W:0]    rel_s1_ff [3];
   logic signed [FIX_W:0]    rel_s1_in [3];
   logic signed [ADJ_W-1:0]  adj_ff [3][3];
   logic signed [ADJ_W-1:0]  adj_in [3][3];
   logic signed [FIX_W-1:0]  a0_s2_ff [3];
   logic signed [FIX_W:0]    rel_s2_ff [3];
   logic signed [WORD_W-1:0] diff [9];

   function automatic logic signed [WORD_W-1:0] mul_fix(
      input logic signed [FIX_W-1:0] a,
      input logic signed [FIX_W-1:0] b
   );
      return WORD_W'(a) * WORD_W'(b);
   endfunction

   // unpack: low column in low half
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mat_in[i][0] = $signed(row_words[2*i][FIX_W-1:0]);
         mat_in[i][1] = $signed(row_words[2*i][WORD_W-1:FIX_W]);
         mat_in[i][2] = $signed(row_words[2*i+1][FIX_W-1:0]);
         mat_in[i][3] = $signed(row_words[2*i+1][WORD_W-1:FIX_W]);
      end
   end

   // cofactor product pairs, index 3*row+col of the adjugate
   always_comb begin
      prod_in[0][0] = mul_fix(mat_ff[1][1], mat_ff[2][2]);
      prod_in[0][1] = mul_fix(mat_ff[1][2], mat_ff[2][1]);
      prod_in[1][0] = mul_fix(mat_ff[0][2], mat_ff[2][1]);
      prod_in[1][1] = mul_fix(mat_ff[0][1], mat_ff[2][2]);
      prod_in[2][0] = mul_fix(mat_ff[0][1], mat_ff[1][2]);
      prod_in[2][1] = mul_fix(mat_ff[0][2], mat_ff[1][1]);
      prod_in[3][0] = mul_fix(mat_ff[1][2], mat_ff[2][0]);
      prod_in[3][1] = mul_fix(mat_ff[1][0], mat_ff[2][2]);
      prod_in[4][0] = mul_fix(mat_ff[0][0], mat_ff[2][2]);
      prod_in[4][1] = mul_fix(mat_ff[0][2], mat_ff[2][0]);
      prod_in[5][0] = mul_fix(mat_ff[0][2], mat_ff[1][0]);
      prod_in[5][1] = mul_fix(mat_ff[0][0], mat_ff[1][2]);
      prod_in[6][0] = mul_fix(mat_ff[1][0], mat_ff[2][1]);
      prod_in[6][1] = mul_fix(mat_ff[1][1], mat_ff[2][0]);
      prod_in[7][0] = mul_fix(mat_ff[0][1], mat_ff[2][0]);
      prod_in[7][1] = mul_fix(mat_ff[0][0], mat_ff[2][1]);
      prod_in[8][0] = mul_fix(mat_ff[0][0], mat_ff[1][1]);
      prod_in[8][1] = mul_fix(mat_ff[0][1], mat_ff[1][0]);
      for (int j = 0; j < 3; j++) begin
         rel_s1_in[j] = (FIX_W+1)'(ray_origin[j]) - (FIX_W+1)'(mat_ff[j][3]);
      end
   end

   // difference never overflows 64 bits; floor shift is a plain slice
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         diff[k] = prod_ff[k][0] - prod_ff[k][1];
         adj_in[k/3][k%3] = diff[k][WORD_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mat_ff <= mat_in;
      end
      if (stage_en[1]) begin
         prod_ff   <= prod_in;
         rel_s1_ff <= rel_s1_in;
         for (int j = 0; j < 3; j++) begin
            a0_s1_ff[j] <= mat_ff[0][j];
         end
      end
      if (stage_en[2]) begin
         adj_ff    <= adj_in;
         a0_s2_ff  <= a0_s1_ff;
         rel_s2_ff <= rel_s1_ff;
      end
   end

   assign adj = adj_ff;
   assign a0  = a0_s2_ff;
   assign rel = rel_s2_ff;

endmodule
`default_nettype wire

### src/rqh_transform.sv
`default_nettype none
// Stages 3..6: determinant, local origin and local direction.
// Sum 0 is det, 1..3 local origin, 4..6 local direction.
module rqh_transform #(
   parameter int FRAC_BITS = rqh_pkg::FRAC_BITS_DEF,
   localparam int ADJ_W = rqh_pkg::WORD_W - FRAC_BITS
) (
   input  logic                              clock,
   input  logic [3:0]                        stage_en,
   input  logic signed [ADJ_W-1:0]           adj [3][3],
   input  logic signed [rqh_pkg::FIX_W-1:0]  a0 [3],
   input  logic signed [rqh_pkg::FIX_W:0]    rel [3],
   input  logic signed [rqh_pkg::FIX_W-1:0]  ray_dir [3],
   output logic signed [rqh_pkg::WORD_W-1:0] det,
   output logic signed [rqh_pkg::WORD_W-1:0] loc_org [3],
   output logic signed [rqh_pkg::WORD_W-1:0] loc_dir [3]
);
   import rqh_pkg::*;

   localparam int HI_W   = ADJ_W - FIX_W;
   localparam int LO_PW  = 2 * FIX_W + 2;
   localparam int HI_PW  = HI_W + FIX_W + 1;
   localparam int PW_A   = ADJ_W + FIX_W + 2;
   localparam int PW_B   = WORD_W + 1 + FRAC_BITS;
   localparam int PW     = (PW_A > PW_B) ? PW_A : PW_B;
   localparam int SH_W   = PW - FRAC_BITS;

   logic signed [ADJ_W-1:0]  adj_op [7][3];
   logic signed [FIX_W:0]    x_op [7][3];
   logic signed [LO_PW-1:0]  plo_ff [7][3];
   logic signed [LO_PW-1:0]  plo_in [7][3];
   logic signed [HI_PW-1:0]  phi_ff [7][3];
   logic signed [HI_PW-1:0]  phi_in [7][3];
   logic signed [PW-1:0]     full [7][3];
   logic signed [SH_W-1:0]   shr [7][3];
   logic signed [WORD_W-1:0] term_ff [7][3];
   logic signed [WORD_W-1:0] term_in [7][3];
   logic signed [WORD_W-1:0] part_ff [7];
   logic signed [WORD_W-1:0] last_ff [7];
   logic signed [WORD_W-1:0] sum_ff [7];

   // operand routing
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         adj_op[0][t] = adj[t][0];
         x_op[0][t]   = (FIX_W+1)'(a0[t]);
         for (int i = 0; i < 3; i++) begin
            adj_op[1+i][t] = adj[i][t];
            x_op[1+i][t]   = rel[t];
            adj_op[4+i][t] = adj[i][t];
            x_op[4+i][t]   = (FIX_W+1)'(ray_dir[t]);
         end
      end
   end

   // adjugate entry split into its low FIX_W bits and the rest, one partial product each
   always_comb begin
      for (int s = 0; s < 7; s++) begin
         for (int t = 0; t < 3; t++) begin
            plo_in[s][t] = LO_PW'($signed({1'b0, adj_op[s][t][FIX_W-1:0]}))
                         * LO_PW'(x_op[s][t]);
            phi_in[s][t] = HI_PW'($signed(adj_op[s][t][ADJ_W-1:FIX_W]))
                         * HI_PW'(x_op[s][t]);
         end
      end
   end

   // rejoin, floor shift, clip to 64 bits
   always_comb begin
      for (int s = 0; s < 7; s++) begin
         for (int t = 0; t < 3; t++) begin
            full[s][t] = (PW'(phi_ff[s][t]) <<< FIX_W) + PW'(plo_ff[s][t]);
            shr[s][t]  = full[s][t][PW-1:FRAC_BITS];
            if ((&shr[s][t][SH_W-1:WORD_W-1]) || !(|shr[s][t][SH_W-1:WORD_W-1])) begin
               term_in[s][t] = shr[s][t][WORD_W-1:0];
            end else begin
               term_in[s][t] = shr[s][t][SH_W-1] ? S64_MIN : S64_MAX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (stage_en[1]) begin
         term_ff <= term_in;
      end
      // clipping order matters: first two terms, then the third
      if (stage_en[2]) begin
         for (int s = 0; s < 7; s++) begin
            part_ff[s] <= sat_add64(term_ff[s][0], term_ff[s][1]);
            last_ff[s] <= term_ff[s][2];
         end
      end
      if (stage_en[3]) begin
         for (int s = 0; s < 7; s++) begin
            sum_ff[s] <= sat_add64(part_ff[s], last_ff[s]);
         end
      end
   end

   assign det = sum_ff[0];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         loc_org[i] = sum_ff[1+i];
         loc_dir[i] = sum_ff[4+i];
      end
   end

endmodule
`default_nettype wire

### src/rqh_bounds.sv
`default_nettype none
// Stages 7..11: exact 128-bit cross products and the square test.
module rqh_bounds (
   input  logic                              clock,
   input  logic [4:0]                        stage_en,
   input  logic signed [rqh_pkg::WORD_W-1:0] det,
   input  logic signed [rqh_pkg::WORD_W-1:0] loc_org [3],
   input  logic signed [rqh_pkg::WORD_W-1:0] loc_dir [3],
   output logic                              hit
);
   import rqh_pkg::*;

   localparam int HALF_W = FIX_W + 1;
   localparam int PP_W   = 2 * HALF_W;
   localparam int WIDE_W = 2 * WORD_W;

   logic signed [WORD_W-1:0] opa [5];
   logic signed [WORD_W-1:0] opb [5];
   logic signed [PP_W-1:0]   pp_ff [5][4];
   logic signed [PP_W-1:0]   pp_in [5][4];
   logic signed [WIDE_W-1:0] prod_ff [5];
   logic signed [WIDE_W-1:0] prod_in [5];
   logic signed [WIDE_W-1:0] dx_ff;
   logic signed [WIDE_W-1:0] dy_ff;
   logic signed [WIDE_W-1:0] lim_raw_ff;
   logic [WIDE_W-1:0]        adx_ff;
   logic [WIDE_W-1:0]        ady_ff;
   logic [WIDE_W-1:0]        lim_ff;
   logic [WIDE_W-1:0]        lim_abs;
   logic                     ok_in;
   logic                     ok_ff [4];
   logic                     hit_ff;

   function automatic logic signed [HALF_W-1:0] hi_half(input logic signed [WORD_W-1:0] v);
      return HALF_W'($signed(v[WORD_W-1:FIX_W]));
   endfunction

   function automatic logic signed [HALF_W-1:0] lo_half(input logic signed [WORD_W-1:0] v);
      return $signed({1'b0, v[FIX_W-1:0]});
   endfunction

   // product pairs: x cross, y cross, det by direction z
   always_comb begin
      opa[0] = loc_org[0]; opb[0] = loc_dir[2];
      opa[1] = loc_org[2]; opb[1] = loc_dir[0];
      opa[2] = loc_org[1]; opb[2] = loc_dir[2];
      opa[3] = loc_org[2]; opb[3] = loc_dir[1];
      opa[4] = det;        opb[4] = loc_dir[2];
      for (int p = 0; p < 5; p++) begin
         pp_in[p][0] = PP_W'(hi_half(opa[p])) * PP_W'(hi_half(opb[p]));
         pp_in[p][1] = PP_W'(hi_half(opa[p])) * PP_W'(lo_half(opb[p]));
         pp_in[p][2] = PP_W'(lo_half(opa[p])) * PP_W'(hi_half(opb[p]));
         pp_in[p][3] = PP_W'(lo_half(opa[p])) * PP_W'(lo_half(opb[p]));
      end
   end

   // singular, parallel and behind-origin cases
   assign ok_in = (det != '0) && (loc_dir[2] != '0)
               && !((loc_org[2] != '0) && (loc_org[2][WORD_W-1] == loc_dir[2][WORD_W-1]));

   always_comb begin
      for (int p = 0; p < 5; p++) begin
         prod_in[p] = (WIDE_W'(pp_ff[p][0]) <<< WORD_W)
                    + ((WIDE_W'(pp_ff[p][1]) + WIDE_W'(pp_ff[p][2])) <<< FIX_W)
                    + WIDE_W'(pp_ff[p][3]);
      end
   end

   assign lim_abs = lim_raw_ff[WIDE_W-1] ? WIDE_W'(-lim_raw_ff) : WIDE_W'(lim_raw_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_ff    <= pp_in;
         ok_ff[0] <= ok_in;
      end
      if (stage_en[1]) begin
         prod_ff  <= prod_in;
         ok_ff[1] <= ok_ff[0];
      end
      if (stage_en[2]) begin
         dx_ff      <= prod_ff[0] - prod_ff[1];
         dy_ff      <= prod_ff[2] - prod_ff[3];
         lim_raw_ff <= prod_ff[4];
         ok_ff[2]   <= ok_ff[1];
      end
      if (stage_en[3]) begin
         adx_ff   <= dx_ff[WIDE_W-1] ? WIDE_W'(-dx_ff) : WIDE_W'(dx_ff);
         ady_ff   <= dy_ff[WIDE_W-1] ? WIDE_W'(-dy_ff) : WIDE_W'(dy_ff);
         lim_ff   <= lim_abs >> 1;
         ok_ff[3] <= ok_ff[2];
      end
      if (stage_en[4]) begin
         hit_ff <= ok_ff[3] && (adx_ff <= lim_ff) && (ady_ff <= lim_ff);
      end
   end

   assign hit = hit_ff;

endmodule
`default_nettype wire

### test/ray_quad_hit_check.sv
`default_nettype none
module ray_quad_hit_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rqh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rqh_pkg::FIX_W-1:0]     csr_wdata,
   rqh_req_if                            req_mon,
   rqh_rsp_if                            rsp_mon,
   output int                            fail_count,
   output int                            hits_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rqh_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             hit;
   } hit_word_type;

   typedef logic signed [WORD_W-1:0]  s64_type;
   typedef logic signed [127:0]       s128_type;

   logic signed [FIX_W-1:0] ray_reg [6];
   hit_word_type            hit_expect_q [$];

   assign hits_pending = hit_expect_q.size();

   // exact product, floor shift, clip to 64 bits
   function automatic s64_type fx_mul(s64_type a, s64_type b);
      s128_type wa, wb, p;
      wa = a;
      wb = b;
      p  = (wa * wb) >>> FB;
      if (p[127:63] == '0 || p[127:63] == '1) return p[63:0];
      return p[127] ? S64_MIN : S64_MAX;
   endfunction

   function automatic s64_type fx_add(s64_type a, s64_type b);
      s64_type s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   // 2x2 minor, 64-bit wrap then floor shift
   function automatic s64_type minor2(s64_type a, s64_type b, s64_type c, s64_type d);
      s64_type x;
      x = a * b - c * d;
      return x >>> FB;
   endfunction

   function automatic logic in_half(s64_type lc, s64_type lz, s64_type dc, s64_type dz,
                                    s64_type det);
      s128_type     w1, w2, w3, w4;
      logic [127:0] dev, lim;
      w1 = lc;
      w2 = dz;
      w3 = lz;
      w4 = dc;
      dev = (w1 * w2) - (w3 * w4);
      if (dev[127]) dev = -dev;
      w3 = det;
      lim = w3 * w2;
      if (lim[127]) lim = -lim;
      lim = lim >> 1;
      return dev <= lim;
   endfunction

   function automatic logic quad_hit(logic [WORD_W-1:0] w [6]);
      s64_type a [3][4];
      s64_type adj [3][3];
      s64_type r [3];
      s64_type dv [3];
      s64_type lo [3];
      s64_type ld [3];
      s64_type det;
      for (int i = 0; i < 3; i++) begin
         a[i][0] = $signed(w[2*i][31:0]);
         a[i][1] = $signed(w[2*i][63:32]);
         a[i][2] = $signed(w[2*i+1][31:0]);
         a[i][3] = $signed(w[2*i+1][63:32]);
      end
      adj[0][0] = minor2(a[1][1], a[2][2], a[1][2], a[2][1]);
      adj[0][1] = minor2(a[0][2], a[2][1], a[0][1], a[2][2]);
      adj[0][2] = minor2(a[0][1], a[1][2], a[0][2], a[1][1]);
      adj[1][0] = minor2(a[1][2], a[2][0], a[1][0], a[2][2]);
      adj[1][1] = minor2(a[0][0], a[2][2], a[0][2], a[2][0]);
      adj[1][2] = minor2(a[0][2], a[1][0], a[0][0], a[1][2]);
      adj[2][0] = minor2(a[1][0], a[2][1], a[1][1], a[2][0]);
      adj[2][1] = minor2(a[0][1], a[2][0], a[0][0], a[2][1]);
      adj[2][2] = minor2(a[0][0], a[1][1], a[0][1], a[1][0]);
      det = fx_add(fx_add(fx_mul(a[0][0], adj[0][0]), fx_mul(a[0][1], adj[1][0])),
                   fx_mul(a[0][2], adj[2][0]));
      for (int j = 0; j < 3; j++) begin
         r[j]  = s64_type'(ray_reg[j]) - a[j][3];
         dv[j] = ray_reg[3+j];
      end
      for (int i = 0; i < 3; i++) begin
         lo[i] = '0;
         ld[i] = '0;
         for (int j = 0; j < 3; j++) begin
            lo[i] = fx_add(lo[i], fx_mul(adj[i][j], r[j]));
            ld[i] = fx_add(ld[i], fx_mul(adj[i][j], dv[j]));
         end
      end
      // singular, parallel, behind the origin
      if (det == 0 || ld[2] == 0) return 1'b0;
      if (lo[2] != 0 && (lo[2][63] == ld[2][63])) return 1'b0;
      return in_half(lo[0], lo[2], ld[0], ld[2], det) &&
             in_half(lo[1], lo[2], ld[1], ld[2], det);
   endfunction

   always @(posedge clock) begin
      logic [WORD_W-1:0] w [6];
      hit_word_type      exp_w;
      if (reset) begin
         for (int i = 0; i < 6; i++) ray_reg[i] <= '0;
         hit_expect_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we && csr_index < 6) ray_reg[csr_index] <= csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            w[0] = req_mon.row0_cols01;
            w[1] = req_mon.row0_cols23;
            w[2] = req_mon.row1_cols01;
            w[3] = req_mon.row1_cols23;
            w[4] = req_mon.row2_cols01;
            w[5] = req_mon.row2_cols23;
            exp_w.tag = req_mon.entity_tag;
            exp_w.hit = quad_hit(w);
            hit_expect_q = {hit_expect_q, exp_w};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (hit_expect_q.size() == 0) begin
               if (fail_count < MAX_SHOWN)
                  $display("unexpected result word tag=%h hit=%b",
                           rsp_mon.result_tag, rsp_mon.hit);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = hit_expect_q.pop_front();
               if (rsp_mon.result_tag !== exp_w.tag || rsp_mon.hit !== exp_w.hit) begin
                  if (fail_count < MAX_SHOWN)
                     $display("mismatch: expected tag=%h hit=%b, got tag=%h hit=%b",
                              exp_w.tag, exp_w.hit, rsp_mon.result_tag, rsp_mon.hit);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

### test/tb_ray_quad_hit_test.sv
`default_nettype none
module tb_ray_quad_hit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rqh_pkg::*;

   localparam logic [31:0] ONE      = 32'h0001_0000;
   localparam logic [31:0] HALF     = 32'h0000_8000;
   localparam logic [31:0] FIX_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] FIX_MIN  = 32'h8000_0000;
   localparam int          WATCHDOG = 5000;
   localparam int          DRAIN    = 30;
   localparam int          N_PHASES = 8;
   localparam int          PER_PHASE = 70;

   typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FIX_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   hits_pending;
   idle_mode_type        idle_mode = IDLE_NONE;
   int                   quiet_cycles = 0;

   rqh_req_if req_chan ();
   rqh_rsp_if rsp_chan ();

   ray_quad_hit_test uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   ray_quad_hit_check checker_i (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .hits_pending(hits_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.row0_cols01 = '0;
      req_chan.row0_cols23 = '0;
      req_chan.row1_cols01 = '0;
      req_chan.row1_cols23 = '0;
      req_chan.row2_cols01 = '0;
      req_chan.row2_cols23 = '0;
      req_chan.entity_tag = '0;
      rsp_chan.ready = 1'b0;
   end

   // receiver stalls
   always @(negedge clock) begin
      case (idle_mode)
         IDLE_DST: rsp_chan.ready <= ($urandom_range(99) >= 82);
         IDLE_BOTH: rsp_chan.ready <= ($urandom_range(99) >= 19);
         default: rsp_chan.ready <= 1'b1;
      endcase
   end

   // watchdog on cycles with no word accepted and no result taken
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("[ray_quad_hit_test] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_fix(int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [31:0] corner_fix();
      case ($urandom_range(4))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hffff_ffff;
         3: return FIX_MAX;
         default: return FIX_MIN;
      endcase
   endfunction

   // entries m[row][col], col 3 is the translation
   task automatic send_xform(logic [31:0] m [3][4], logic [15:0] tag);
      while ((idle_mode == IDLE_SRC && $urandom_range(99) < 82) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 19)) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.row0_cols01 <= {m[0][1], m[0][0]};
      req_chan.row0_cols23 <= {m[0][3], m[0][2]};
      req_chan.row1_cols01 <= {m[1][1], m[1][0]};
      req_chan.row1_cols23 <= {m[1][3], m[1][2]};
      req_chan.row2_cols01 <= {m[2][1], m[2][0]};
      req_chan.row2_cols23 <= {m[2][3], m[2][2]};
      req_chan.entity_tag  <= tag;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_diag(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                            logic [15:0] tag);
      logic [31:0] m [3][4];
      foreach (m[i, j]) m[i][j] = '0;
      m[0][0] = sx; m[1][1] = sy; m[2][2] = sz;
      m[0][3] = tx; m[1][3] = ty; m[2][3] = tz;
      send_xform(m, tag);
   endtask

   task automatic write_ray(logic [31:0] r [6]);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= r[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drain then let the pipe settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (hits_pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic random_xform(logic [15:0] tag);
      logic [31:0] m [3][4];
      int          pick;
      pick = $urandom_range(99);
      foreach (m[i, j]) begin
         if (pick < 75) begin
            // well-formed: scaled near-identity, small skew and shift
            if (i == j) m[i][j] = 32'($urandom_range(ONE / 4, 4 * ONE));
            else if (j == 3) m[i][j] = rand_fix(i == 2 ? 2 * ONE : 3 * HALF);
            else m[i][j] = ($urandom_range(3) == 0) ? rand_fix(ONE / 4) : '0;
            if (i == j && $urandom_range(15) == 0) m[i][j] = -m[i][j];
         end else if (pick < 90) begin
            m[i][j] = $urandom;
         end else begin
            m[i][j] = corner_fix();
         end
      end
      send_xform(m, tag);
   endtask

   initial begin
      logic [31:0] ray [6];
      logic [31:0] m [3][4];

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // straight down from z = 5
      ray = '{32'h0, 32'h0, 5 * ONE, 32'h0, 32'h0, -ONE};
      write_ray(ray);

      // directed words
      send_diag(ONE, ONE, ONE, 32'h0, 32'h0, 32'h0, 16'h0000);
      send_diag(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hffff);
      send_diag(ONE, ONE, ONE, HALF, 32'h0, 32'h0, 16'h0002);
      send_diag(ONE, ONE, ONE, HALF + 1, 32'h0, 32'h0, 16'h0003);
      send_diag(ONE, ONE, ONE, -HALF, -HALF, 32'h0, 16'h0004);
      send_diag(ONE, ONE, ONE, 32'h0, HALF + 1, 32'h0, 16'h0005);
      send_diag(ONE, ONE, ONE, 32'h0, 32'h0, 5 * ONE, 16'h0006);
      send_diag(ONE, ONE, ONE, 32'h0, 32'h0, 6 * ONE, 16'h0007);
      send_diag(2 * ONE, 2 * ONE, ONE, ONE, 32'h0, 32'h0, 16'h0008);
      send_diag(-ONE, ONE, -ONE, 32'h0, 32'h0, -ONE, 16'h0009);
      // quad tipped on edge: direction lies in its plane
      foreach (m[i, j]) m[i][j] = '0;
      m[0][0] = ONE; m[1][2] = ONE; m[2][1] = ONE;
      send_xform(m, 16'h000a);
      foreach (m[i, j]) m[i][j] = FIX_MAX;
      send_xform(m, 16'h000b);
      foreach (m[i, j]) m[i][j] = FIX_MIN;
      send_xform(m, 16'h000c);
      send_diag(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, 16'h000d);
      send_diag(32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0, 16'h000e);
      foreach (m[i, j]) m[i][j] = 32'hffff_ffff;
      send_xform(m, 16'h000f);
      foreach (m[i, j]) m[i][j] = 32'h5555_aaaa ^ {i[15:0], j[15:0]};
      send_xform(m, 16'ha5a5);
      wait_drained();

      // origin on the plane: t = 0 is a hit
      ray = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, -ONE};
      write_ray(ray);
      send_diag(ONE, ONE, ONE, 32'h0, 32'h0, 32'h0, 16'h0010);
      send_diag(ONE, ONE, ONE, 32'h0, 32'h0, -ONE, 16'h0011);
      wait_drained();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         idle_mode = idle_mode_type'(ph % 4);
         case (ph)
            5: ray = '{FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN};
            6: ray = '{FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX};
            7: foreach (ray[i]) ray[i] = $urandom;
            default: ray = '{rand_fix(ONE), rand_fix(ONE), 32'($urandom_range(3 * ONE, 8 * ONE)),
                             rand_fix(ONE / 5), rand_fix(ONE / 5),
                             -32'($urandom_range(ONE, 2 * ONE))};
         endcase
         write_ray(ray);
         for (int n = 0; n < PER_PHASE; n++) begin
            random_xform(16'($urandom));
            // sender holds off until every result is back
            if (ph == 2 && n == PER_PHASE / 2) begin
               req_chan.valid <= 1'b0;
               while (hits_pending != 0) @(negedge clock);
            end
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("[ray_quad_hit_test] OK");
      else
         $display("[ray_quad_hit_test] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
src/rqh_pkg.sv
src/rqh_if.sv
src/rqh_adjugate.sv
src/rqh_transform.sv
src/rqh_bounds.sv
src/ray_quad_hit_test.sv
test/ray_quad_hit_check.sv
test/tb_ray_quad_hit_test.sv
